FILE: sv/base64_stream_decoder_unit_assert.svh
// Assertion macros used by the checker of the base64 stream decoder.
`ifndef BASE64_STREAM_DECODER_UNIT_ASSERT_SVH
`define BASE64_STREAM_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clock, quiet during reset.
`define B64D_ASSERT_IMPLY(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("assertion failed");

// Next-cycle implication, sampled on clock, quiet during reset.
`define B64D_ASSERT_NEXT(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("assertion failed");

`endif

FILE: sv/b64d_pkg.sv
`timescale 1ns / 1ps

package b64d_pkg;

   localparam int unsigned MAX_RESULTS = 5;
   localparam int unsigned COUNT_W     = 3;

   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_PAD   = 8'h3D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_LF    = 8'h0A;

   typedef enum logic [1:0] {
      KIND_DATA,
      KIND_PAD,
      KIND_SKIP,
      KIND_BAD
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [5:0] sextet;
   } class_type;

   typedef struct packed {
      logic [7:0] char_in;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       end_of_stream;
      logic       bad_input;
   } rsp_type;

   // Results of one character: bytes in order, then an optional status entry.
   typedef struct packed {
      logic [MAX_RESULTS-1:0][7:0] bytes;
      logic [COUNT_W-1:0]          count;
      logic                        status;
      logic                        bad;
      logic                        eos;
   } bundle_type;

   function automatic class_type classify(input logic [7:0] c);
      class_type r;
      r.kind   = KIND_DATA;
      r.sextet = 6'd0;
      priority if (c >= 8'h41 && c <= 8'h5A) begin
         r.sextet = 6'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         r.sextet = 6'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         r.sextet = 6'(c - 8'h30 + 8'd52);
      end else if (c == CHAR_PLUS) begin
         r.sextet = 6'd62;
      end else if (c == CHAR_SLASH) begin
         r.sextet = 6'd63;
      end else if (c == CHAR_PAD) begin
         r.kind = KIND_PAD;
      end else if (c == CHAR_SPACE || c == CHAR_LF) begin
         r.kind = KIND_SKIP;
      end else begin
         r.kind = KIND_BAD;
      end
      return r;
   endfunction

endpackage

FILE: sv/b64d_in_stage.sv
`timescale 1ns / 1ps

module b64d_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  b64d_pkg::req_type req_data,
   input  logic              pop,
   output logic              in_valid,
   output b64d_pkg::req_type in_data
);

   logic              valid_ff;
   logic              valid_in;
   b64d_pkg::req_type data_ff;

   assign req_ready = !valid_ff || pop;
   assign in_valid  = valid_ff;
   assign in_data   = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff <= req_data;
      end
   end

endmodule

FILE: sv/b64d_decode.sv
`timescale 1ns / 1ps

module b64d_decode (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  b64d_pkg::req_type    in_data,
   input  logic                 out_free,
   output logic                 pop,
   output logic                 load,
   output b64d_pkg::bundle_type bundle
);

   logic [23:0] group_ff, group_in;
   logic [1:0]  sextets_ff, sextets_in;
   logic [1:0]  pads_ff, pads_in;
   logic [1:0]  held_cnt_ff, held_cnt_in;
   logic        err_ff, err_in;
   logic [7:0]  held0_ff, held1_ff;

   b64d_pkg::class_type cls;
   logic        active, reject, take, complete;
   logic [23:0] group_add, group_new;
   logic [1:0]  sextets_new, pads_new, held_new, rel;
   logic        err_new, bad_end, status;
   logic [2:0]  emit_n, count;
   logic [b64d_pkg::MAX_RESULTS-1:0][7:0] seq;

   always_comb begin
      cls    = b64d_pkg::classify(in_data.char_in);
      active = !err_ff && cls.kind != b64d_pkg::KIND_SKIP;
      reject = cls.kind == b64d_pkg::KIND_BAD ||
               (cls.kind == b64d_pkg::KIND_PAD && pads_ff == 2'd2);
      take   = active && !reject;

      unique case (sextets_ff)
         2'd0:    group_add = {cls.sextet, 18'd0};
         2'd1:    group_add = {6'd0, cls.sextet, 12'd0};
         2'd2:    group_add = {12'd0, cls.sextet, 6'd0};
         default: group_add = {18'd0, cls.sextet};
      endcase
      group_new = group_ff | group_add;

      complete    = take && sextets_ff == 2'd3;
      sextets_new = take ? sextets_ff + 2'd1 : sextets_ff;
      pads_new    = (take && cls.kind == b64d_pkg::KIND_PAD) ? pads_ff + 2'd1 : pads_ff;
      err_new     = err_ff || (active && reject);

      // held bytes first, then the finished group
      unique case (held_cnt_ff)
         2'd0:    seq = {8'd0, 8'd0, group_new[7:0], group_new[15:8], group_new[23:16]};
         2'd1:    seq = {8'd0, group_new[7:0], group_new[15:8], group_new[23:16], held0_ff};
         default: seq = {group_new[7:0], group_new[15:8], group_new[23:16], held1_ff,
                         held0_ff};
      endcase

      // all but the two newest bytes go out
      emit_n   = complete ? 3'({1'b0, held_cnt_ff} + 3'd1) : 3'd0;
      held_new = complete ? 2'd2 : held_cnt_ff;
      rel      = 2'd2 - pads_new;
      if (rel > held_new) begin
         rel = held_new;
      end

      bad_end = err_new || sextets_new != 2'd0;
      status  = in_data.is_last && (bad_end || rel == 2'd0);
      count   = emit_n;
      if (in_data.is_last) begin
         count = status ? emit_n + 3'd1 : emit_n + {1'b0, rel};
      end

      bundle.bytes  = seq;
      bundle.count  = count;
      bundle.status = status;
      bundle.bad    = in_data.is_last && bad_end;
      bundle.eos    = in_data.is_last;

      pop  = in_valid && (count == 3'd0 || out_free);
      load = pop && count != 3'd0;

      group_in    = group_ff;
      sextets_in  = sextets_ff;
      pads_in     = pads_ff;
      held_cnt_in = held_cnt_ff;
      err_in      = err_ff;
      if (pop) begin
         if (in_data.is_last) begin
            group_in    = 24'd0;
            sextets_in  = 2'd0;
            pads_in     = 2'd0;
            held_cnt_in = 2'd0;
            err_in      = 1'b0;
         end else begin
            group_in    = complete ? 24'd0 : (take ? group_new : group_ff);
            sextets_in  = sextets_new;
            pads_in     = pads_new;
            held_cnt_in = held_new;
            err_in      = err_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_ff    <= 24'd0;
         sextets_ff  <= 2'd0;
         pads_ff     <= 2'd0;
         held_cnt_ff <= 2'd0;
         err_ff      <= 1'b0;
      end else begin
         group_ff    <= group_in;
         sextets_ff  <= sextets_in;
         pads_ff     <= pads_in;
         held_cnt_ff <= held_cnt_in;
         err_ff      <= err_in;
      end
   end

   // keep the two newest group bytes back
   always_ff @(posedge clock) begin
      if (pop && complete && !in_data.is_last) begin
         held0_ff <= group_new[15:8];
         held1_ff <= group_new[7:0];
      end
   end

endmodule

FILE: sv/b64d_out_stage.sv
`timescale 1ns / 1ps

module b64d_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  b64d_pkg::bundle_type bundle,
   output logic                 out_free,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output b64d_pkg::rsp_type    rsp_data
);

   logic                 valid_ff, valid_in;
   logic [2:0]           idx_ff, idx_in;
   b64d_pkg::bundle_type bun_ff;
   logic                 tail, stat;

   assign tail     = idx_ff == bun_ff.count - 3'd1;
   assign stat     = bun_ff.status && tail;
   assign out_free = !valid_ff || (rsp_ready && tail);
   assign rsp_valid = valid_ff;

   always_comb begin
      rsp_data.out_byte      = stat ? 8'd0 : bun_ff.bytes[idx_ff];
      rsp_data.has_byte      = !stat;
      rsp_data.end_of_stream = bun_ff.eos && tail;
      rsp_data.bad_input     = bun_ff.bad && tail;
   end

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = 3'd0;
      end else if (valid_ff && rsp_ready) begin
         // advance through the entries, drop after the last transfer
         if (tail) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bun_ff <= bundle;
      end
   end

endmodule

FILE: sv/base64_stream_decoder_unit.sv
`timescale 1ns / 1ps
// The first result of a character is offered once it has passed the input register and been
// loaded into the result register, at the earliest.
// Throughput: one character per cycle while the result register is free or it has no results;
// a character holds the result register until its last result is taken; the next one waits.
// Up to 5 results per character, one result transfer per cycle at the output.
// Reset clears the group, counts, error flag and both valid bits.

module base64_stream_decoder_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  b64d_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output b64d_pkg::rsp_type rsp_data
);

   logic                 pop, load, in_valid, out_free;
   b64d_pkg::req_type    in_data;
   b64d_pkg::bundle_type bundle;

   b64d_in_stage u_in (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .pop       (pop),
      .in_valid  (in_valid),
      .in_data   (in_data)
   );

   b64d_decode u_dec (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_valid),
      .in_data  (in_data),
      .out_free (out_free),
      .pop      (pop),
      .load     (load),
      .bundle   (bundle)
   );

   b64d_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .bundle    (bundle),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: sv/b64d_checker.sv
`timescale 1ns / 1ps
`include "base64_stream_decoder_unit_assert.svh"

module b64d_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input b64d_pkg::rsp_type rsp_data
);

   `B64D_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `B64D_ASSERT_IMPLY(a_bad_ends, rsp_valid && rsp_data.bad_input, rsp_data.end_of_stream)
   `B64D_ASSERT_IMPLY(a_status_ends, rsp_valid && !rsp_data.has_byte, rsp_data.end_of_stream)
   `B64D_ASSERT_IMPLY(a_status_zero, rsp_valid && !rsp_data.has_byte, rsp_data.out_byte == 8'd0)
   `B64D_ASSERT_IMPLY(a_idle_ready, !rsp_valid, req_ready)

endmodule

bind base64_stream_decoder_unit b64d_checker u_chk (.*);
